>>> sv/wcags_pkg.sv
// ----------------------------------------------------------------------------
// wcags_pkg: shared constants for the weighted complex Gram sums unit
// Field widths, datapath widths, sequence lengths and multiplier op codes.
// ----------------------------------------------------------------------------
package wcags_pkg;

    // Port field widths
    localparam int IN_W      = 16;   // Q1.15 coefficient parts
    localparam int WEIGHT_W  = 16;   // unsigned Q4.12 weight
    localparam int PAIR_W    = 18;   // Q3.15 scaled pair
    localparam int SUM_W     = 56;   // Q26.30 running sums
    localparam int DOUT_W    = 64;   // Q44.20 determinant

    // Square root of weight * 2^12
    localparam int WFRAC     = 12;
    localparam int RAD_W     = WEIGHT_W + WFRAC;   // 28-bit radicand
    localparam int ROOT_W    = RAD_W / 2;          // 14-bit root
    localparam int REM_W     = ROOT_W + 1;

    // Shared signed multiplier
    localparam int MUL_W     = 29;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SPLIT_W   = SUM_W / 2;          // sum halves for the determinant

    // Gram term: sum or difference of two 18x18 products
    localparam int GPROD_W   = 2 * PAIR_W;
    localparam int GTERM_W   = GPROD_W + 2;
    localparam int ACC_EXT_W = SUM_W + 2;

    // Exact determinant and its Q.60 -> Q.20 rounding
    localparam int DET_W     = 114;
    localparam int DET_SHIFT = 40;
    localparam int RND_W     = DET_W - DET_SHIFT;

    // Sequence lengths and counter
    localparam int SQRT_N    = ROOT_W;
    localparam int SCALE_N   = 4;
    localparam int GRAM_N    = 8;
    localparam int DET_N     = 12;
    localparam int CNT_W     = 4;

    // Operation carried along with each multiplier product
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_SCALE = 2'd1;
    localparam logic [1:0] OP_GRAM  = 2'd2;
    localparam logic [1:0] OP_DET   = 2'd3;

endpackage

>>> sv/weighted_complex_am_gram_sums_unit.sv
// ----------------------------------------------------------------------------
// weighted_complex_am_gram_sums_unit: weighted complex antenna-pattern sums
// Scales a complex coefficient pair by sqrt(weight), keeps four running sums
// and on the batch's last beat returns the sums and the Gram determinant.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A weighted beat runs the bit-serial square
// root of weight*2^12 (one root bit per cycle), then scales the four parts
// and forms the eight products of the sums, both on one shared 29x29 signed
// multiplier with a registered product, then loads the result and returns
// to idle. In unit-weight mode the root and scaling are skipped. A last beat
// also forms and sums the 12 partial products of AB - C^2 - E^2 on the same
// multiplier and then rounds the determinant.
// The result sits in an output register; a new beat is accepted while it
// waits, and the block only stalls when the next result is ready before the
// previous one was taken.
module weighted_complex_am_gram_sums_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_wr_data,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [wcags_pkg::IN_W-1:0]      s_a_re,
    input  logic signed [wcags_pkg::IN_W-1:0]      s_a_im,
    input  logic signed [wcags_pkg::IN_W-1:0]      s_b_re,
    input  logic signed [wcags_pkg::IN_W-1:0]      s_b_im,
    input  logic        [wcags_pkg::WEIGHT_W-1:0]  s_weight,
    input  logic                                   s_last_item,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [wcags_pkg::PAIR_W-1:0]    m_wa_re,
    output logic signed [wcags_pkg::PAIR_W-1:0]    m_wa_im,
    output logic signed [wcags_pkg::PAIR_W-1:0]    m_wb_re,
    output logic signed [wcags_pkg::PAIR_W-1:0]    m_wb_im,
    output logic signed [wcags_pkg::SUM_W-1:0]     m_sum_aa,
    output logic signed [wcags_pkg::SUM_W-1:0]     m_sum_bb,
    output logic signed [wcags_pkg::SUM_W-1:0]     m_sum_ab_real,
    output logic signed [wcags_pkg::SUM_W-1:0]     m_sum_ab_imag,
    output logic signed [wcags_pkg::DOUT_W-1:0]    m_determinant,
    output logic                                   m_batch_done
);

    localparam int IN_W      = wcags_pkg::IN_W;
    localparam int PAIR_W    = wcags_pkg::PAIR_W;
    localparam int SUM_W     = wcags_pkg::SUM_W;
    localparam int DOUT_W    = wcags_pkg::DOUT_W;
    localparam int RAD_W     = wcags_pkg::RAD_W;
    localparam int ROOT_W    = wcags_pkg::ROOT_W;
    localparam int REM_W     = wcags_pkg::REM_W;
    localparam int MUL_W     = wcags_pkg::MUL_W;
    localparam int PROD_W    = wcags_pkg::PROD_W;
    localparam int SPLIT_W   = wcags_pkg::SPLIT_W;
    localparam int GPROD_W   = wcags_pkg::GPROD_W;
    localparam int GTERM_W   = wcags_pkg::GTERM_W;
    localparam int ACC_EXT_W = wcags_pkg::ACC_EXT_W;
    localparam int DET_W     = wcags_pkg::DET_W;
    localparam int DET_SHIFT = wcags_pkg::DET_SHIFT;
    localparam int RND_W     = wcags_pkg::RND_W;
    localparam int CNT_W     = wcags_pkg::CNT_W;
    localparam int WFRAC     = wcags_pkg::WFRAC;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_GRAM  = 3'd3;
    localparam logic [2:0] ST_DET   = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(wcags_pkg::SQRT_N - 1);
    localparam logic [CNT_W-1:0] SCALE_END = CNT_W'(wcags_pkg::SCALE_N);
    localparam logic [CNT_W-1:0] GRAM_END  = CNT_W'(wcags_pkg::GRAM_N);
    localparam logic [CNT_W-1:0] DET_END   = CNT_W'(wcags_pkg::DET_N);

    localparam logic signed [PROD_W-1:0] SCALE_HALF = PROD_W'(1) << (WFRAC - 1);
    localparam logic signed [DET_W-1:0]  DET_HALF   = DET_W'(1) << (DET_SHIFT - 1);
    localparam logic signed [PAIR_W-1:0] PAIR_MAX   = {1'b0, {(PAIR_W-1){1'b1}}};
    localparam logic signed [PAIR_W-1:0] PAIR_MIN   = {1'b1, {(PAIR_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [DOUT_W-1:0] DOUT_MAX   = {1'b0, {(DOUT_W-1){1'b1}}};
    localparam logic signed [DOUT_W-1:0] DOUT_MIN   = {1'b1, {(DOUT_W-1){1'b0}}};

    // Control
    logic [2:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             use_weights_reg;
    logic             last_reg;

    // Captured beat
    logic signed [IN_W-1:0] in_a_re_reg, in_a_im_reg, in_b_re_reg, in_b_im_reg;

    // Square root
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_sh, trial, rem_diff;

    // Scaled pair
    logic signed [PAIR_W-1:0] pa_re_reg, pa_im_reg, pb_re_reg, pb_im_reg;

    // Shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [1:0]               iss_op;
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0]               prod_op_reg;
    logic [CNT_W-1:0]         prod_idx_reg;

    // Sums
    logic signed [SUM_W-1:0]   acc_aa_reg, acc_bb_reg, acc_ab_real_reg, acc_ab_imag_reg;
    logic signed [GPROD_W-1:0] tmp_reg;
    logic signed [GTERM_W-1:0] gram_term;
    logic signed [SUM_W-1:0]   acc_sel, acc_sat;
    logic signed [ACC_EXT_W-1:0] acc_sum;

    // Scale rounding
    logic signed [PROD_W-1:0] sc_sum, sc_q;
    logic signed [PAIR_W-1:0] sc_sat;

    // Determinant
    logic signed [SUM_W-1:0]  det_x, det_y;
    logic signed [DET_W-1:0]  det_reg, det_ext, det_part;
    logic signed [DET_W-1:0]  det_rsum;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [DOUT_W-1:0] det_sat;

    // Output register
    logic                     m_valid_reg;
    logic                     out_free;
    logic                     s_fire;
    logic signed [PAIR_W-1:0] m_wa_re_reg, m_wa_im_reg, m_wb_re_reg, m_wb_im_reg;
    logic signed [SUM_W-1:0]  m_sum_aa_reg, m_sum_bb_reg, m_sum_ab_real_reg, m_sum_ab_imag_reg;
    logic signed [DOUT_W-1:0] m_det_reg;
    logic                     m_done_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Compute one root bit per cycle (restoring method)
    always_comb begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        rem_diff = rem_sh - trial;
        if (rem_sh >= trial) begin
            rem_next  = rem_diff[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // Select determinant factors: AB, then CC, then EE
    always_comb begin
        unique case (cnt_reg[3:2])
            2'd0: begin
                det_x = acc_aa_reg;
                det_y = acc_bb_reg;
            end
            2'd1: begin
                det_x = acc_ab_real_reg;
                det_y = acc_ab_real_reg;
            end
            default: begin
                det_x = acc_ab_imag_reg;
                det_y = acc_ab_imag_reg;
            end
        endcase
    end

    // Drive the shared multiplier operands from the sequencer
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        iss_op = wcags_pkg::OP_NONE;
        unique case (state_reg)
            ST_SCALE: begin
                if (cnt_reg < SCALE_END) begin
                    iss_op = wcags_pkg::OP_SCALE;
                    mul_b  = {{(MUL_W-ROOT_W){1'b0}}, root_reg};
                    case (cnt_reg[1:0])
                        2'd0:    mul_a = {{(MUL_W-IN_W){in_a_re_reg[IN_W-1]}}, in_a_re_reg};
                        2'd1:    mul_a = {{(MUL_W-IN_W){in_a_im_reg[IN_W-1]}}, in_a_im_reg};
                        2'd2:    mul_a = {{(MUL_W-IN_W){in_b_re_reg[IN_W-1]}}, in_b_re_reg};
                        default: mul_a = {{(MUL_W-IN_W){in_b_im_reg[IN_W-1]}}, in_b_im_reg};
                    endcase
                end
            end
            ST_GRAM: begin
                if (cnt_reg < GRAM_END) begin
                    iss_op = wcags_pkg::OP_GRAM;
                    case (cnt_reg[2:0])
                        3'd0: begin
                            mul_a = {{(MUL_W-PAIR_W){pa_re_reg[PAIR_W-1]}}, pa_re_reg};
                            mul_b = {{(MUL_W-PAIR_W){pa_re_reg[PAIR_W-1]}}, pa_re_reg};
                        end
                        3'd1: begin
                            mul_a = {{(MUL_W-PAIR_W){pa_im_reg[PAIR_W-1]}}, pa_im_reg};
                            mul_b = {{(MUL_W-PAIR_W){pa_im_reg[PAIR_W-1]}}, pa_im_reg};
                        end
                        3'd2: begin
                            mul_a = {{(MUL_W-PAIR_W){pb_re_reg[PAIR_W-1]}}, pb_re_reg};
                            mul_b = {{(MUL_W-PAIR_W){pb_re_reg[PAIR_W-1]}}, pb_re_reg};
                        end
                        3'd3: begin
                            mul_a = {{(MUL_W-PAIR_W){pb_im_reg[PAIR_W-1]}}, pb_im_reg};
                            mul_b = {{(MUL_W-PAIR_W){pb_im_reg[PAIR_W-1]}}, pb_im_reg};
                        end
                        3'd4: begin
                            mul_a = {{(MUL_W-PAIR_W){pa_re_reg[PAIR_W-1]}}, pa_re_reg};
                            mul_b = {{(MUL_W-PAIR_W){pb_re_reg[PAIR_W-1]}}, pb_re_reg};
                        end
                        3'd5: begin
                            mul_a = {{(MUL_W-PAIR_W){pa_im_reg[PAIR_W-1]}}, pa_im_reg};
                            mul_b = {{(MUL_W-PAIR_W){pb_im_reg[PAIR_W-1]}}, pb_im_reg};
                        end
                        3'd6: begin
                            mul_a = {{(MUL_W-PAIR_W){pa_re_reg[PAIR_W-1]}}, pa_re_reg};
                            mul_b = {{(MUL_W-PAIR_W){pb_im_reg[PAIR_W-1]}}, pb_im_reg};
                        end
                        default: begin
                            mul_a = {{(MUL_W-PAIR_W){pa_im_reg[PAIR_W-1]}}, pa_im_reg};
                            mul_b = {{(MUL_W-PAIR_W){pb_re_reg[PAIR_W-1]}}, pb_re_reg};
                        end
                    endcase
                end
            end
            ST_DET: begin
                if (cnt_reg < DET_END) begin
                    iss_op = wcags_pkg::OP_DET;
                    // low halves are unsigned, high halves carry the sign
                    if (cnt_reg[1]) begin
                        mul_a = {det_x[SUM_W-1], det_x[SUM_W-1:SPLIT_W]};
                    end else begin
                        mul_a = {1'b0, det_x[SPLIT_W-1:0]};
                    end
                    if (cnt_reg[0]) begin
                        mul_b = {det_y[SUM_W-1], det_y[SUM_W-1:SPLIT_W]};
                    end else begin
                        mul_b = {1'b0, det_y[SPLIT_W-1:0]};
                    end
                end
            end
            default: begin
                iss_op = wcags_pkg::OP_NONE;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Register the product with its operation tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_op_reg <= wcags_pkg::OP_NONE;
        end else begin
            prod_op_reg <= iss_op;
        end
        prod_reg     <= mul_p;
        prod_idx_reg <= cnt_reg;
    end

    // Round x*s from Q.27 to Q.15 (half up) and saturate to 18 bits
    always_comb begin
        sc_sum = prod_reg + SCALE_HALF;
        sc_q   = sc_sum >>> WFRAC;
        if (sc_q[PROD_W-1:PAIR_W-1] == {(PROD_W-PAIR_W+1){sc_q[PAIR_W-1]}}) begin
            sc_sat = sc_q[PAIR_W-1:0];
        end else if (sc_q[PROD_W-1]) begin
            sc_sat = PAIR_MIN;
        end else begin
            sc_sat = PAIR_MAX;
        end
    end

    // Form the pair term and the saturated accumulator update
    always_comb begin
        if (prod_idx_reg[2:0] == 3'd7) begin
            gram_term = GTERM_W'(tmp_reg) - GTERM_W'($signed(prod_reg[GPROD_W-1:0]));
        end else begin
            gram_term = GTERM_W'(tmp_reg) + GTERM_W'($signed(prod_reg[GPROD_W-1:0]));
        end
        case (prod_idx_reg[2:1])
            2'd0:    acc_sel = acc_aa_reg;
            2'd1:    acc_sel = acc_bb_reg;
            2'd2:    acc_sel = acc_ab_real_reg;
            default: acc_sel = acc_ab_imag_reg;
        endcase
        acc_sum = ACC_EXT_W'(acc_sel) + ACC_EXT_W'(gram_term);
        if (acc_sum[ACC_EXT_W-1:SUM_W-1] == {(ACC_EXT_W-SUM_W+1){acc_sum[SUM_W-1]}}) begin
            acc_sat = acc_sum[SUM_W-1:0];
        end else if (acc_sum[ACC_EXT_W-1]) begin
            acc_sat = SUM_MIN;
        end else begin
            acc_sat = SUM_MAX;
        end
    end

    // Align the determinant partial product
    always_comb begin
        det_ext = DET_W'(prod_reg);
        case (prod_idx_reg[1:0])
            2'd0:    det_part = det_ext;
            2'd3:    det_part = det_ext <<< (2 * SPLIT_W);
            default: det_part = det_ext <<< SPLIT_W;
        endcase
        det_rsum = det_reg + DET_HALF;
        if (rnd_reg[RND_W-1:DOUT_W-1] == {(RND_W-DOUT_W+1){rnd_reg[DOUT_W-1]}}) begin
            det_sat = rnd_reg[DOUT_W-1:0];
        end else if (rnd_reg[RND_W-1]) begin
            det_sat = DOUT_MIN;
        end else begin
            det_sat = DOUT_MAX;
        end
    end

    // Sequencer, beat capture and square root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            use_weights_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                use_weights_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        cnt_reg   <= '0;
                        state_reg <= use_weights_reg ? ST_SQRT : ST_GRAM;
                    end
                end
                ST_SQRT: begin
                    if (cnt_reg == SQRT_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SCALE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SCALE: begin
                    if (cnt_reg == SCALE_END) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_GRAM;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_GRAM: begin
                    if (cnt_reg == GRAM_END) begin
                        cnt_reg   <= '0;
                        state_reg <= last_reg ? ST_DET : ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DET: begin
                    if (cnt_reg == DET_END) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ROUND: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end

        // Capture the beat
        if (s_fire) begin
            in_a_re_reg <= s_a_re;
            in_a_im_reg <= s_a_im;
            in_b_re_reg <= s_b_re;
            in_b_im_reg <= s_b_im;
            last_reg    <= s_last_item;
            rad_reg     <= {s_weight, {WFRAC{1'b0}}};
            rem_reg     <= '0;
            root_reg    <= '0;
        end else if (state_reg == ST_SQRT) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    // Load the pair: unchanged in unit mode, scaled in weighted mode
    always_ff @(posedge aclk) begin
        if (s_fire && !use_weights_reg) begin
            pa_re_reg <= PAIR_W'(s_a_re);
            pa_im_reg <= PAIR_W'(s_a_im);
            pb_re_reg <= PAIR_W'(s_b_re);
            pb_im_reg <= PAIR_W'(s_b_im);
        end else if (prod_op_reg == wcags_pkg::OP_SCALE) begin
            case (prod_idx_reg[1:0])
                2'd0:    pa_re_reg <= sc_sat;
                2'd1:    pa_im_reg <= sc_sat;
                2'd2:    pb_re_reg <= sc_sat;
                default: pb_im_reg <= sc_sat;
            endcase
        end
    end

    // Accumulate the sums; clear them once a batch result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_aa_reg      <= '0;
            acc_bb_reg      <= '0;
            acc_ab_real_reg <= '0;
            acc_ab_imag_reg <= '0;
        end else if (state_reg == ST_OUT && out_free && last_reg) begin
            acc_aa_reg      <= '0;
            acc_bb_reg      <= '0;
            acc_ab_real_reg <= '0;
            acc_ab_imag_reg <= '0;
        end else if (prod_op_reg == wcags_pkg::OP_GRAM && prod_idx_reg[0]) begin
            case (prod_idx_reg[2:1])
                2'd0:    acc_aa_reg      <= acc_sat;
                2'd1:    acc_bb_reg      <= acc_sat;
                2'd2:    acc_ab_real_reg <= acc_sat;
                default: acc_ab_imag_reg <= acc_sat;
            endcase
        end
        // hold the first product of each pair
        if (prod_op_reg == wcags_pkg::OP_GRAM && !prod_idx_reg[0]) begin
            tmp_reg <= prod_reg[GPROD_W-1:0];
        end
    end

    // Build AB - C^2 - E^2 exactly, then round Q.60 to Q.20
    always_ff @(posedge aclk) begin
        if (state_reg == ST_GRAM) begin
            det_reg <= '0;
        end else if (prod_op_reg == wcags_pkg::OP_DET) begin
            if (prod_idx_reg[3:2] == 2'd0) begin
                det_reg <= det_reg + det_part;
            end else begin
                det_reg <= det_reg - det_part;
            end
        end
        if (state_reg == ST_ROUND) begin
            rnd_reg <= det_rsum[DET_W-1:DET_SHIFT];
        end
    end

    // Output register: load when free, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_wa_re_reg       <= pa_re_reg;
            m_wa_im_reg       <= pa_im_reg;
            m_wb_re_reg       <= pb_re_reg;
            m_wb_im_reg       <= pb_im_reg;
            m_sum_aa_reg      <= last_reg ? acc_aa_reg : '0;
            m_sum_bb_reg      <= last_reg ? acc_bb_reg : '0;
            m_sum_ab_real_reg <= last_reg ? acc_ab_real_reg : '0;
            m_sum_ab_imag_reg <= last_reg ? acc_ab_imag_reg : '0;
            m_det_reg         <= last_reg ? det_sat : '0;
            m_done_reg        <= last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_wa_re       = m_wa_re_reg;
    assign m_wa_im       = m_wa_im_reg;
    assign m_wb_re       = m_wb_re_reg;
    assign m_wb_im       = m_wb_im_reg;
    assign m_sum_aa      = m_sum_aa_reg;
    assign m_sum_bb      = m_sum_bb_reg;
    assign m_sum_ab_real = m_sum_ab_real_reg;
    assign m_sum_ab_imag = m_sum_ab_imag_reg;
    assign m_determinant = m_det_reg;
    assign m_batch_done  = m_done_reg;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for weighted_complex_am_gram_sums_unit
// Drives coefficient beats through the valid/ready input channel in random
// bursts, stalls the result channel on its own pattern, and checks every
// result beat against a typed-in value or an in-bench model of the scaling,
// running sums and batch-end Gram determinant. A directed table comes first, then random
// batches in both weighting modes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths shared with the design
    localparam int IN_W      = wcags_pkg::IN_W;
    localparam int WEIGHT_W  = wcags_pkg::WEIGHT_W;
    localparam int PAIR_W    = wcags_pkg::PAIR_W;
    localparam int SUM_W     = wcags_pkg::SUM_W;
    localparam int DOUT_W    = wcags_pkg::DOUT_W;
    localparam int WFRAC     = wcags_pkg::WFRAC;
    localparam int ROOT_W    = wcags_pkg::ROOT_W;
    localparam int DET_SHIFT = wcags_pkg::DET_SHIFT;

    typedef struct packed {
        logic signed [IN_W-1:0]     a_re;
        logic signed [IN_W-1:0]     a_im;
        logic signed [IN_W-1:0]     b_re;
        logic signed [IN_W-1:0]     b_im;
        logic        [WEIGHT_W-1:0] weight;
        logic                       last;
    } coeff_beat_t;

    typedef struct packed {
        logic signed [PAIR_W-1:0] wa_re;
        logic signed [PAIR_W-1:0] wa_im;
        logic signed [PAIR_W-1:0] wb_re;
        logic signed [PAIR_W-1:0] wb_im;
        logic signed [SUM_W-1:0]  sum_aa;
        logic signed [SUM_W-1:0]  sum_bb;
        logic signed [SUM_W-1:0]  sum_ab_real;
        logic signed [SUM_W-1:0]  sum_ab_imag;
        logic signed [DOUT_W-1:0] det;
        logic                     done;
    } gram_result_t;

    typedef struct {
        logic         weighted;
        coeff_beat_t  beat;
        logic         typed;
        gram_result_t want;
    } stim_row_t;

    localparam logic signed [IN_W-1:0] COEF_MIN = 16'sh8000;
    localparam logic signed [IN_W-1:0] COEF_MAX = 16'sh7FFF;
    localparam int NUM_ROWS      = 19;
    localparam int NUM_PHASES    = 4;
    localparam int PHASE_BEATS   = 190;
    localparam int MAX_PRINTS    = 40;
    localparam longint SUM_HI    = 64'sd36028797018963967;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam longint PAIR_HI   = 131071;
    localparam longint PAIR_LO   = -131072;

    localparam gram_result_t RES_NONE      = '0;
    localparam gram_result_t RES_ZERO_DONE =
        '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 56'sd0, 56'sd0, 56'sd0, 56'sd0, 64'sd0, 1'b1};

    // Directed beats: expected result typed in where it is obvious, else predicted
    stim_row_t stim_table [NUM_ROWS] = '{
        // zeros right after reset close an empty batch
        '{1'b1, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b1},
          1'b1, RES_ZERO_DONE},
        // zero weight wipes the pair
        '{1'b1, '{COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, 16'h0000, 1'b0},
          1'b1, RES_NONE},
        // weight of exactly one passes the pair through
        '{1'b1, '{COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 16'h1000, 1'b0},
          1'b1, '{18'sd32767, -18'sd32768, -18'sd32768, 18'sd32767,
                  56'sd0, 56'sd0, 56'sd0, 56'sd0, 64'sd0, 1'b0}},
        '{1'b1, '{COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 16'hFFFF, 1'b0}, 1'b0, RES_NONE},
        '{1'b1, '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 16'hFFFF, 1'b1}, 1'b0, RES_NONE},
        '{1'b1, '{16'sh0001, 16'shFFFF, 16'shFFFF, 16'sh0001, 16'h0001, 1'b0},
          1'b0, RES_NONE},
        '{1'b1, '{16'sh3039, 16'shA460, 16'shFFF9, COEF_MAX, 16'h8000, 1'b1},
          1'b0, RES_NONE},
        '{1'b1, '{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'h1800, 1'b0},
          1'b0, RES_NONE},
        '{1'b1, '{16'sh0800, 16'shF800, 16'shF800, 16'sh0800, 16'h0FFF, 1'b1},
          1'b0, RES_NONE},
        // unit weights: all-minimum batch of one, determinant cancels to zero
        '{1'b0, '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 16'hFFFF, 1'b1},
          1'b1, '{-18'sd32768, -18'sd32768, -18'sd32768, -18'sd32768,
                  56'sd2147483648, 56'sd2147483648, 56'sd2147483648, 56'sd0,
                  64'sd0, 1'b1}},
        '{1'b0, '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, 16'h0000, 1'b0},
          1'b1, '{18'sd32767, 18'sd32767, 18'sd32767, -18'sd32768,
                  56'sd0, 56'sd0, 56'sd0, 56'sd0, 64'sd0, 1'b0}},
        '{1'b0, '{COEF_MIN, 16'sh0000, 16'sh0000, COEF_MAX, 16'h1234, 1'b1},
          1'b0, RES_NONE},
        '{1'b0, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b1},
          1'b1, RES_ZERO_DONE},
        '{1'b0, '{16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'hAAAA, 1'b0},
          1'b0, RES_NONE},
        '{1'b0, '{COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 16'h5555, 1'b0}, 1'b0, RES_NONE},
        '{1'b0, '{16'shFFFD, 16'sh0005, 16'sh0007, 16'shFFF7, 16'h0000, 1'b1},
          1'b0, RES_NONE},
        // back to weighted, mostly with the largest weight
        '{1'b1, '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 16'hFFFF, 1'b0}, 1'b0, RES_NONE},
        '{1'b1, '{COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, 16'h7FFF, 1'b0}, 1'b0, RES_NONE},
        '{1'b1, '{16'sh4000, 16'shC000, 16'shC000, 16'sh4000, 16'hFFFF, 1'b1},
          1'b0, RES_NONE}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic                       cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [IN_W-1:0]     s_a_re;
    logic signed [IN_W-1:0]     s_a_im;
    logic signed [IN_W-1:0]     s_b_re;
    logic signed [IN_W-1:0]     s_b_im;
    logic        [WEIGHT_W-1:0] s_weight;
    logic                       s_last_item;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [PAIR_W-1:0]   m_wa_re;
    logic signed [PAIR_W-1:0]   m_wa_im;
    logic signed [PAIR_W-1:0]   m_wb_re;
    logic signed [PAIR_W-1:0]   m_wb_im;
    logic signed [SUM_W-1:0]    m_sum_aa;
    logic signed [SUM_W-1:0]    m_sum_bb;
    logic signed [SUM_W-1:0]    m_sum_ab_real;
    logic signed [SUM_W-1:0]    m_sum_ab_imag;
    logic signed [DOUT_W-1:0]   m_determinant;
    logic                       m_batch_done;

    // Model state: weighting mode and the four running sums
    logic   weights_on = 1'b1;
    longint aa_total = 0;
    longint bb_total = 0;
    longint abr_total = 0;
    longint abi_total = 0;

    gram_result_t pending_results [$];
    int           err_count = 0;
    int           result_idx = 0;
    int           burst_left = 0;
    logic [15:0]  rx_cycle = '0;
    int           rx_hold = 0;

    weighted_complex_am_gram_sums_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_re        (s_a_re),
        .s_a_im        (s_a_im),
        .s_b_re        (s_b_re),
        .s_b_im        (s_b_im),
        .s_weight      (s_weight),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_wa_re       (m_wa_re),
        .m_wa_im       (m_wa_im),
        .m_wb_re       (m_wb_re),
        .m_wb_im       (m_wb_im),
        .m_sum_aa      (m_sum_aa),
        .m_sum_bb      (m_sum_bb),
        .m_sum_ab_real (m_sum_ab_real),
        .m_sum_ab_imag (m_sum_ab_imag),
        .m_determinant (m_determinant),
        .m_batch_done  (m_batch_done)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // floor(sqrt(weight * 2^12)), one root bit at a time
    function automatic longint weight_root(logic [WEIGHT_W-1:0] w);
        longint rad;
        longint root;
        longint trial;
        rad = longint'(w) << WFRAC;
        root = 0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = root | (64'sd1 << i);
            if (trial * trial <= rad)
                root = trial;
        end
        return root;
    endfunction

    // Q.27 product back to Q.15, round half up, clip to the pair range
    function automatic longint scale_by_root(longint x, longint root);
        longint v;
        v = (x * root + 2048) >>> WFRAC;
        if (v > PAIR_HI) v = PAIR_HI;
        if (v < PAIR_LO) v = PAIR_LO;
        return v;
    endfunction

    function automatic longint clip_sum(longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    // Advance the running sums by one beat and form its result
    function automatic gram_result_t predict_gram_beat(coeff_beat_t b);
        gram_result_t r;
        longint ar, ai, br, bi, root;
        logic signed [127:0] sa, sb, sc, se, det_full;
        logic signed [127:0] det_hi;
        logic signed [127:0] det_lo;
        det_hi = 128'sh7FFF_FFFF_FFFF_FFFF;
        det_lo = -det_hi - 1;
        ar = {{48{b.a_re[IN_W-1]}}, b.a_re};
        ai = {{48{b.a_im[IN_W-1]}}, b.a_im};
        br = {{48{b.b_re[IN_W-1]}}, b.b_re};
        bi = {{48{b.b_im[IN_W-1]}}, b.b_im};
        if (weights_on) begin
            root = weight_root(b.weight);
            ar = scale_by_root(ar, root);
            ai = scale_by_root(ai, root);
            br = scale_by_root(br, root);
            bi = scale_by_root(bi, root);
        end
        aa_total  = clip_sum(aa_total + ar * ar + ai * ai);
        bb_total  = clip_sum(bb_total + br * br + bi * bi);
        abr_total = clip_sum(abr_total + ar * br + ai * bi);
        abi_total = clip_sum(abi_total + ar * bi - ai * br);
        r = '0;
        r.wa_re = ar[PAIR_W-1:0];
        r.wa_im = ai[PAIR_W-1:0];
        r.wb_re = br[PAIR_W-1:0];
        r.wb_im = bi[PAIR_W-1:0];
        if (b.last) begin
            r.sum_aa      = aa_total[SUM_W-1:0];
            r.sum_bb      = bb_total[SUM_W-1:0];
            r.sum_ab_real = abr_total[SUM_W-1:0];
            r.sum_ab_imag = abi_total[SUM_W-1:0];
            // exact AB - C^2 - E^2 in Q.60, rounded half up to Q.20, clipped
            sa = aa_total;
            sb = bb_total;
            sc = abr_total;
            se = abi_total;
            det_full = sa * sb - sc * sc - se * se;
            det_full = (det_full + 128'sd549755813888) >>> DET_SHIFT;
            if (det_full > det_hi) det_full = det_hi;
            if (det_full < det_lo) det_full = det_lo;
            r.det  = det_full[DOUT_W-1:0];
            r.done = 1'b1;
            aa_total  = 0;
            bb_total  = 0;
            abr_total = 0;
            abi_total = 0;
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pick_coef();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h1000;
            3: return 16'h0001;
            4: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (err_count < MAX_PRINTS)
            $display("ERROR: result beat %0d, %s: got %h, expected %h",
                     result_idx, field, got, want);
        err_count++;
    endtask

    // Offer one beat, hold it until taken, then queue its expected result
    task automatic send_beat(coeff_beat_t b, logic typed, gram_result_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_valid     <= 1'b1;
        s_a_re      <= b.a_re;
        s_a_im      <= b.a_im;
        s_b_re      <= b.b_re;
        s_b_im      <= b.b_im;
        s_weight    <= b.weight;
        s_last_item <= b.last;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (typed) begin
            void'(predict_gram_beat(b));
            pending_results.push_back(want);
        end else begin
            pending_results.push_back(predict_gram_beat(b));
        end
    endtask

    // Drain all results, then write the weighting mode
    task automatic set_weighting(logic weighted);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= weighted;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        weights_on = weighted;
        burst_left = 0;
    endtask

    // Result side stall pattern: free-running, random, periodic, long holds
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[11:10])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= (rx_cycle[4:0] >= 5'd9);
            default: begin
                if (rx_hold != 0) begin
                    rx_hold <= rx_hold - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_hold <= $urandom_range(5, 40);
                end
            end
        endcase
    end

    // Compare each taken result beat with the oldest expectation
    always @(posedge aclk) begin
        gram_result_t got;
        gram_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_wa_re, m_wa_im, m_wb_re, m_wb_im, m_sum_aa, m_sum_bb,
                   m_sum_ab_real, m_sum_ab_imag, m_determinant, m_batch_done};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.wa_re !== want.wa_re)
                    report_mismatch("wa_re", got.wa_re, want.wa_re);
                if (got.wa_im !== want.wa_im)
                    report_mismatch("wa_im", got.wa_im, want.wa_im);
                if (got.wb_re !== want.wb_re)
                    report_mismatch("wb_re", got.wb_re, want.wb_re);
                if (got.wb_im !== want.wb_im)
                    report_mismatch("wb_im", got.wb_im, want.wb_im);
                if (got.sum_aa !== want.sum_aa)
                    report_mismatch("sum_aa", got.sum_aa, want.sum_aa);
                if (got.sum_bb !== want.sum_bb)
                    report_mismatch("sum_bb", got.sum_bb, want.sum_bb);
                if (got.sum_ab_real !== want.sum_ab_real)
                    report_mismatch("sum_ab_real", got.sum_ab_real, want.sum_ab_real);
                if (got.sum_ab_imag !== want.sum_ab_imag)
                    report_mismatch("sum_ab_imag", got.sum_ab_imag, want.sum_ab_imag);
                if (got.det !== want.det)
                    report_mismatch("determinant", got.det, want.det);
                if (got.done !== want.done)
                    report_mismatch("batch_done", got.done, want.done);
            end
            result_idx <= result_idx + 1;
        end
    end

    initial begin
        coeff_beat_t beat;
        int          batch_left;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        s_a_re      = '0;
        s_a_im      = '0;
        s_b_re      = '0;
        s_b_im      = '0;
        s_weight    = '0;
        s_last_item = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_weighting(1'b1);

        // Walk the directed table, switching mode only when idle
        foreach (stim_table[i]) begin
            if (stim_table[i].weighted != weights_on)
                set_weighting(stim_table[i].weighted);
            send_beat(stim_table[i].beat, stim_table[i].typed, stim_table[i].want);
        end

        // Random batches; a batch may run across a mode change
        batch_left = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_weighting(phase[0]);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (batch_left == 0)
                    batch_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30);
                beat.a_re   = pick_coef();
                beat.a_im   = pick_coef();
                beat.b_re   = pick_coef();
                beat.b_im   = pick_coef();
                beat.weight = pick_weight();
                beat.last   = (batch_left == 1);
                batch_left--;
                send_beat(beat, 1'b0, RES_NONE);
            end
        end

        // Drain and let any stray beat show up
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_count == 0)
            $display("weighted_complex_am_gram_sums_unit test passed");
        else
            $display("weighted_complex_am_gram_sums_unit test failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1000000;
        $display("weighted_complex_am_gram_sums_unit test failed");
        $finish;
    end

endmodule
